>>> rtl/core/assert_macros.svh
// Assertion macros for the channel/spatial scale gradient unit.
// Compiled to nothing when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset
`define CSG_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that the consequent holds in the cycle after the antecedent
`define CSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CSG_ASSERT(lbl, clk, rst_n, prop, msg)
`define CSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/csg_pkg.sv
// Shared types and constants for the channel/spatial scale gradient unit.
// No dependencies; used by every module of the block.
package csg_pkg;

    // Default store depths
    localparam int CHANNEL_SLOTS_DEF = 1024;
    localparam int SPATIAL_SLOTS_DEF = 4096;

    // Width of one rescaled weight-gradient term (|term| <= 2^29)
    localparam int TERM_W = 31;

    // Operation codes
    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_ELEMENT = 2'd1,
        OP_READ_CH = 2'd2,
        OP_READ_SP = 2'd3
    } op_t;

    // Control states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_RND,
        ST_ACC,
        ST_READ,
        ST_CLEAR
    } state_t;

    // Input item
    typedef struct packed {
        op_t                operation;
        logic signed [15:0] x_value;
        logic signed [15:0] channel_weight;
        logic signed [15:0] spatial_weight;
        logic signed [15:0] output_grad;
        logic        [9:0]  channel_slot;
        logic        [11:0] spatial_slot;
    } csg_cmd_t;

    // Result item
    typedef struct packed {
        logic signed [15:0] y_value;
        logic signed [15:0] x_grad;
        logic signed [31:0] gradient_value;
        logic               saturated;
    } csg_result_t;

    // Sequencer outputs
    typedef struct packed {
        logic busy;
        logic accept;
        logic sweep;
        logic acc;
        logic read;
        logic clear_done;
    } csg_ctl_t;

    // Per-store port controls
    typedef struct packed {
        logic rd_en;
        logic acc_en;
        logic clr_en;
    } csg_store_ctl_t;

    // Product pipeline outputs
    typedef struct packed {
        logic signed [15:0]       y_value;
        logic signed [15:0]       x_grad;
        logic                     clip;
        logic signed [TERM_W-1:0] term_c;
        logic signed [TERM_W-1:0] term_s;
    } csg_mul_out_t;

endpackage

>>> rtl/core/csg_mul.sv
// Three-stage product pipeline: pair products, triple products, Q8.8 rescale.
// Depends on csg_pkg.
module csg_mul (
    input  logic              clk,
    input  csg_pkg::csg_cmd_t cmd,
    output csg_pkg::csg_mul_out_t mul_out
);

    logic signed [31:0] xwc_reg;
    logic signed [31:0] dywc_reg;
    logic signed [31:0] dyx_reg;
    logic signed [15:0] wc_reg;
    logic signed [15:0] ws_reg;
    logic signed [47:0] p_y_reg;
    logic signed [47:0] p_xg_reg;
    logic signed [47:0] p_c_reg;
    logic signed [47:0] p_s_reg;
    csg_pkg::csg_mul_out_t out_reg;
    csg_pkg::csg_mul_out_t out_next;

    // Round half up from Q24.24 to Q8.8
    function automatic logic signed [31:0] rescale(input logic signed [47:0] p);
        logic signed [47:0] s;
        begin
            s = p + 48'sd32768;
            return s[47:16];
        end
    endfunction

    // Clamp to 16 bits; top bit flags a clip
    function automatic logic [16:0] clamp16(input logic signed [31:0] v);
        logic [16:0] r;
        begin
            if (v > 32'sd32767)
            begin
                r = {1'b1, 16'h7fff};
            end
            else if (v < -32'sd32768)
            begin
                r = {1'b1, 16'h8000};
            end
            else
            begin
                r = {1'b0, v[15:0]};
            end
            return r;
        end
    endfunction

    // Stage 1: pair products
    always_ff @(posedge clk)
    begin
        xwc_reg  <= 32'(cmd.x_value) * 32'(cmd.channel_weight);
        dywc_reg <= 32'(cmd.output_grad) * 32'(cmd.channel_weight);
        dyx_reg  <= 32'(cmd.output_grad) * 32'(cmd.x_value);
        wc_reg   <= cmd.channel_weight;
        ws_reg   <= cmd.spatial_weight;
    end

    // Stage 2: triple products, exact Q24.24
    always_ff @(posedge clk)
    begin
        p_y_reg  <= 48'(xwc_reg) * 48'(ws_reg);
        p_xg_reg <= 48'(dywc_reg) * 48'(ws_reg);
        p_c_reg  <= 48'(dyx_reg) * 48'(ws_reg);
        p_s_reg  <= 48'(dyx_reg) * 48'(wc_reg);
    end

    // Stage 3: rescale and clamp the element results
    always_comb
    begin
        logic signed [31:0] r_y;
        logic signed [31:0] r_xg;
        logic signed [31:0] r_c;
        logic signed [31:0] r_s;
        logic [16:0]        c_y;
        logic [16:0]        c_xg;
        r_y  = rescale(p_y_reg);
        r_xg = rescale(p_xg_reg);
        r_c  = rescale(p_c_reg);
        r_s  = rescale(p_s_reg);
        c_y  = clamp16(r_y);
        c_xg = clamp16(r_xg);
        out_next.y_value = c_y[15:0];
        out_next.x_grad  = c_xg[15:0];
        out_next.clip    = c_y[16] | c_xg[16];
        out_next.term_c  = r_c[csg_pkg::TERM_W-1:0];
        out_next.term_s  = r_s[csg_pkg::TERM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign mul_out = out_reg;

endmodule

>>> rtl/core/csg_store.sv
// One gradient store: synchronous memory with registered read and a
// saturating read-modify-write accumulate port. Depends on csg_pkg.
module csg_store #(
    parameter int  DEPTH = csg_pkg::CHANNEL_SLOTS_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                              clk,
    input  csg_pkg::csg_store_ctl_t           ctl,
    input  logic [AW-1:0]                     rd_addr,
    input  logic [AW-1:0]                     wr_addr,
    input  logic signed [csg_pkg::TERM_W-1:0] term,
    output logic signed [31:0]                rd_data,
    output logic                              acc_clip
);

    logic signed [31:0] store_mem [DEPTH];
    logic signed [31:0] rd_data_reg;
    logic signed [32:0] sum;
    logic signed [31:0] acc_value;
    logic signed [31:0] wr_data;
    logic               wr_en;

    // Add the term to the entry read at accept; clip to 32 bits
    always_comb
    begin
        sum      = 33'(rd_data_reg) + 33'(term);
        acc_clip = sum[32] ^ sum[31];
        if (acc_clip)
        begin
            acc_value = sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else
        begin
            acc_value = sum[31:0];
        end
        wr_en   = ctl.acc_en | ctl.clr_en;
        wr_data = ctl.clr_en ? '0 : acc_value;
    end

    // Read on accept, hold the data; write back or zero
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/csg_ctrl.sv
// Sequencer: item phases and the store clearing sweep.
// Depends on csg_pkg.
module csg_ctrl #(
    parameter int  SWEEP_LEN = csg_pkg::SPATIAL_SLOTS_DEF,
    localparam int CLRW      = (SWEEP_LEN > 1) ? $clog2(SWEEP_LEN) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  csg_pkg::op_t     operation,
    output csg_pkg::csg_ctl_t ctl,
    output logic [CLRW-1:0]  sweep_addr
);

    csg_pkg::state_t state_reg;
    csg_pkg::state_t state_next;
    logic [CLRW-1:0] cnt_reg;
    logic [CLRW-1:0] cnt_next;
    logic            last;

    assign last = (cnt_reg == CLRW'(SWEEP_LEN - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            csg_pkg::ST_INIT:
            begin
                if (last)
                begin
                    state_next = csg_pkg::ST_IDLE;
                end
            end
            csg_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (operation)
                        csg_pkg::OP_CLEAR:   state_next = csg_pkg::ST_CLEAR;
                        csg_pkg::OP_ELEMENT: state_next = csg_pkg::ST_MUL1;
                        csg_pkg::OP_READ_CH,
                        csg_pkg::OP_READ_SP: state_next = csg_pkg::ST_READ;
                    endcase
                end
            end
            csg_pkg::ST_MUL1: state_next = csg_pkg::ST_MUL2;
            csg_pkg::ST_MUL2: state_next = csg_pkg::ST_RND;
            csg_pkg::ST_RND:  state_next = csg_pkg::ST_ACC;
            csg_pkg::ST_ACC:  state_next = csg_pkg::ST_IDLE;
            csg_pkg::ST_READ: state_next = csg_pkg::ST_IDLE;
            csg_pkg::ST_CLEAR:
            begin
                if (last)
                begin
                    state_next = csg_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        ctl.busy       = (state_reg != csg_pkg::ST_IDLE);
        ctl.accept     = start & (state_reg == csg_pkg::ST_IDLE);
        ctl.sweep      = (state_reg == csg_pkg::ST_INIT) | (state_reg == csg_pkg::ST_CLEAR);
        ctl.acc        = (state_reg == csg_pkg::ST_ACC);
        ctl.read       = (state_reg == csg_pkg::ST_READ);
        ctl.clear_done = (state_reg == csg_pkg::ST_CLEAR) & last;
    end

    // Advance the sweep address, wrap to zero at the end
    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.sweep)
        begin
            cnt_next = last ? '0 : cnt_reg + CLRW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csg_pkg::ST_INIT;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign sweep_addr = cnt_reg;

endmodule

>>> rtl/core/channel_spatial_scale_grad_unit.sv
// Top level of the channel/spatial scale gradient unit.
// Depends on csg_pkg, assert_macros.svh, csg_ctrl, csg_mul, csg_store.
//
//  channel  | ports                    | handshake
//  ---------+--------------------------+-------------------------------------
//  item in  | start, busy, cmd         | taken at an edge with start & !busy
//  result   | done, result             | one-cycle strobe, receiver never stalls
//
// Element item: busy through two multiply stages, rescale and store read-modify-
// write; result on the following cycle, next item taken at that cycle's end.
// Read item: busy while the result is taken from the registered store read port.
// Clear item: busy while the sweep zeroes one entry per cycle over the larger store.
// After reset the same zeroing pass runs with busy high and no result.
`include "assert_macros.svh"

module channel_spatial_scale_grad_unit #(
    parameter int CHANNEL_SLOTS = csg_pkg::CHANNEL_SLOTS_DEF,
    parameter int SPATIAL_SLOTS = csg_pkg::SPATIAL_SLOTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  csg_pkg::csg_cmd_t    cmd,
    output logic                 busy,
    output logic                 done,
    output csg_pkg::csg_result_t result
);

    localparam int CW        = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;
    localparam int SW        = (SPATIAL_SLOTS > 1) ? $clog2(SPATIAL_SLOTS) : 1;
    localparam int SWEEP_LEN = (CHANNEL_SLOTS > SPATIAL_SLOTS) ? CHANNEL_SLOTS
                                                               : SPATIAL_SLOTS;
    localparam int CLRW      = (SWEEP_LEN > 1) ? $clog2(SWEEP_LEN) : 1;

    csg_pkg::csg_ctl_t      ctl;
    csg_pkg::csg_cmd_t      cmd_reg;
    csg_pkg::csg_mul_out_t  mul_out;
    csg_pkg::csg_store_ctl_t ch_ctl;
    csg_pkg::csg_store_ctl_t sp_ctl;
    csg_pkg::csg_result_t   result_reg;
    csg_pkg::csg_result_t   result_next;
    logic                   done_reg;
    logic                   res_load;
    logic [CLRW-1:0]        sweep_addr;
    logic [31:0]            ch_slot_in;
    logic [31:0]            sp_slot_in;
    logic [31:0]            ch_slot_held;
    logic [31:0]            sp_slot_held;
    logic                   ch_in_range;
    logic                   sp_in_range;
    logic                   ch_clr_hit;
    logic                   sp_clr_hit;
    logic [CW-1:0]          ch_wr_addr;
    logic [SW-1:0]          sp_wr_addr;
    logic signed [31:0]     ch_rd_data;
    logic signed [31:0]     sp_rd_data;
    logic                   ch_clip;
    logic                   sp_clip;

    // Sequencer
    csg_ctrl #(
        .SWEEP_LEN (SWEEP_LEN)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .operation  (cmd.operation),
        .ctl        (ctl),
        .sweep_addr (sweep_addr)
    );

    // Hold the accepted item
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg <= cmd;
        end
    end

    // Product pipeline
    csg_mul u_mul (
        .clk     (clk),
        .cmd     (cmd_reg),
        .mul_out (mul_out)
    );

    // Slot decoding and range checks
    always_comb
    begin
        ch_slot_in   = 32'(cmd.channel_slot);
        sp_slot_in   = 32'(cmd.spatial_slot);
        ch_slot_held = 32'(cmd_reg.channel_slot);
        sp_slot_held = 32'(cmd_reg.spatial_slot);
        ch_in_range  = ch_slot_held < 32'(CHANNEL_SLOTS);
        sp_in_range  = sp_slot_held < 32'(SPATIAL_SLOTS);
        ch_clr_hit   = 32'(sweep_addr) < 32'(CHANNEL_SLOTS);
        sp_clr_hit   = 32'(sweep_addr) < 32'(SPATIAL_SLOTS);
        ch_wr_addr   = ctl.sweep ? sweep_addr[CW-1:0] : ch_slot_held[CW-1:0];
        sp_wr_addr   = ctl.sweep ? sweep_addr[SW-1:0] : sp_slot_held[SW-1:0];
        ch_ctl.rd_en  = ctl.accept;
        ch_ctl.acc_en = ctl.acc & ch_in_range;
        ch_ctl.clr_en = ctl.sweep & ch_clr_hit;
        sp_ctl.rd_en  = ctl.accept;
        sp_ctl.acc_en = ctl.acc & sp_in_range;
        sp_ctl.clr_en = ctl.sweep & sp_clr_hit;
    end

    // Channel gradient store
    csg_store #(
        .DEPTH (CHANNEL_SLOTS)
    ) u_ch_store (
        .clk      (clk),
        .ctl      (ch_ctl),
        .rd_addr  (ch_slot_in[CW-1:0]),
        .wr_addr  (ch_wr_addr),
        .term     (mul_out.term_c),
        .rd_data  (ch_rd_data),
        .acc_clip (ch_clip)
    );

    // Spatial gradient store
    csg_store #(
        .DEPTH (SPATIAL_SLOTS)
    ) u_sp_store (
        .clk      (clk),
        .ctl      (sp_ctl),
        .rd_addr  (sp_slot_in[SW-1:0]),
        .wr_addr  (sp_wr_addr),
        .term     (mul_out.term_s),
        .rd_data  (sp_rd_data),
        .acc_clip (sp_clip)
    );

    // Form the result item
    always_comb
    begin
        result_next = '0;
        res_load    = ctl.acc | ctl.read | ctl.clear_done;
        priority if (ctl.acc)
        begin
            result_next.y_value   = mul_out.y_value;
            result_next.x_grad    = mul_out.x_grad;
            result_next.saturated = mul_out.clip | (ch_in_range & ch_clip)
                                    | (sp_in_range & sp_clip);
        end
        else if (ctl.read)
        begin
            if (cmd_reg.operation == csg_pkg::OP_READ_CH)
            begin
                result_next.gradient_value = ch_in_range ? ch_rd_data : '0;
            end
            else
            begin
                result_next.gradient_value = sp_in_range ? sp_rd_data : '0;
            end
        end
        else
        begin
            result_next = '0;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            result_reg <= result_next;
        end
    end

    // Strobe one cycle per item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_load;
        end
    end

    assign busy   = ctl.busy;
    assign done   = done_reg;
    assign result = result_reg;

    // Checks
    `CSG_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "item accepted but unit not busy")
    `CSG_ASSERT(a_done_idle, clk, rst_n, !done || !busy, "result strobe while unit busy")
    `CSG_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done, "result strobe held two cycles")

endmodule

>>> test/tb.sv
// Testbench for channel_spatial_scale_grad_unit: checks scaled outputs, input gradients and
// the channel/spatial weight-gradient stores against a built-in predictor.
// Depends on csg_pkg and the RTL of the block.
module tb;

    localparam int CH_SLOTS    = csg_pkg::CHANNEL_SLOTS_DEF;
    localparam int SP_SLOTS    = csg_pkg::SPATIAL_SLOTS_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int ITEM_COUNT  = 1200;
    localparam int MAX_CLEARS  = 8;
    localparam int MSG_CAP     = 200;

    // One queued item with its lead-in gap and an optional wait for all results
    typedef struct packed {
        logic              drain;
        logic [7:0]        gap;
        csg_pkg::csg_cmd_t cmd;
    } pend_t;

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    csg_pkg::csg_cmd_t    cmd   = '0;
    logic                 busy;
    logic                 done;
    csg_pkg::csg_result_t result;

    pend_t                pending_q[$];
    csg_pkg::csg_result_t expected_q[$];
    logic signed [31:0]   ch_grad [CH_SLOTS];
    logic signed [31:0]   sp_grad [SP_SLOTS];
    int                   err_cnt   = 0;
    int                   cycle_cnt = 0;
    int                   idle_left = 0;
    bit                   gap_armed = 1'b0;

    channel_spatial_scale_grad_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #6 clk = ~clk;

    // Round a Q24.24 triple product half up to Q8.8
    function automatic longint q88_round(longint p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    // Clip a Q8.8 value to 16 bits, raising the flag when clipped
    function automatic logic signed [15:0] clip16(longint v, ref bit sat);
        if (v > 32767)
        begin
            sat = 1'b1;
            return 16'sh7fff;
        end
        if (v < -32768)
        begin
            sat = 1'b1;
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Add a term to a store entry with 32-bit saturation
    function automatic logic signed [31:0] acc_sat(logic signed [31:0] old, longint term,
                                                   ref bit sat);
        longint s;
        s = longint'(old) + term;
        if (s > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 32'sh7fffffff;
        end
        if (s < -64'sd2147483648)
        begin
            sat = 1'b1;
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

    // Compute the result of one item and update the gradient stores
    function automatic csg_pkg::csg_result_t scale_grad_predict(csg_pkg::csg_cmd_t c);
        csg_pkg::csg_result_t r;
        longint               x;
        longint               wc;
        longint               ws;
        longint               dy;
        bit                   sat;
        r   = '0;
        sat = 1'b0;
        x   = longint'($signed(c.x_value));
        wc  = longint'($signed(c.channel_weight));
        ws  = longint'($signed(c.spatial_weight));
        dy  = longint'($signed(c.output_grad));
        case (c.operation)
            csg_pkg::OP_CLEAR:
            begin
                foreach (ch_grad[i]) ch_grad[i] = '0;
                foreach (sp_grad[i]) sp_grad[i] = '0;
            end
            csg_pkg::OP_ELEMENT:
            begin
                r.y_value = clip16(q88_round(x * wc * ws), sat);
                r.x_grad  = clip16(q88_round(dy * wc * ws), sat);
                if (int'(c.channel_slot) < CH_SLOTS)
                    ch_grad[c.channel_slot] =
                        acc_sat(ch_grad[c.channel_slot], q88_round(dy * x * ws), sat);
                if (int'(c.spatial_slot) < SP_SLOTS)
                    sp_grad[c.spatial_slot] =
                        acc_sat(sp_grad[c.spatial_slot], q88_round(dy * x * wc), sat);
            end
            csg_pkg::OP_READ_CH:
            begin
                if (int'(c.channel_slot) < CH_SLOTS)
                    r.gradient_value = ch_grad[c.channel_slot];
            end
            default:
            begin
                if (int'(c.spatial_slot) < SP_SLOTS)
                    r.gradient_value = sp_grad[c.spatial_slot];
            end
        endcase
        r.saturated = sat;
        return r;
    endfunction

    function automatic csg_pkg::csg_cmd_t make_cmd(csg_pkg::op_t op, logic [15:0] x,
                                                   logic [15:0] wc, logic [15:0] ws,
                                                   logic [15:0] dy,
                                                   logic [9:0] cs, logic [11:0] ss);
        csg_pkg::csg_cmd_t c;
        c.operation      = op;
        c.x_value        = x;
        c.channel_weight = wc;
        c.spatial_weight = ws;
        c.output_grad    = dy;
        c.channel_slot   = cs;
        c.spatial_slot   = ss;
        return c;
    endfunction

    function automatic void add_item(csg_pkg::csg_cmd_t c, int gap, bit drain);
        pend_t p;
        p.drain = drain;
        p.gap   = gap[7:0];
        p.cmd   = c;
        pending_q.push_back(p);
    endfunction

    // Mix extremes, small magnitudes and fully random Q8.8 values
    function automatic logic [15:0] rand_q88();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0)
        begin
            case ($urandom_range(4))
                0: return 16'h8000;
                1: return 16'h7fff;
                2: return 16'h0000;
                3: return 16'hffff;
                default: return 16'h0001;
            endcase
        end
        if (pick < 4) return 16'($signed($urandom_range(1024)) - 512);
        return 16'($urandom);
    endfunction

    // Favor a few hot slots so gradients build up and reads return data
    function automatic logic [9:0] rand_ch_slot();
        if ($urandom_range(9) < 6)
            return ($urandom_range(4) == 0) ? 10'd1023 : 10'($urandom_range(3));
        return 10'($urandom_range(1023));
    endfunction

    function automatic logic [11:0] rand_sp_slot();
        if ($urandom_range(9) < 6)
            return ($urandom_range(4) == 0) ? 12'd4095 : 12'($urandom_range(3));
        return 12'($urandom_range(4095));
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int rand_gap();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6) return 0;
        if (pick < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            err_cnt++;
            if (err_cnt <= MSG_CAP)
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Drive items: hold start until taken, honor gaps and drain requests
    always @(posedge clk)
    begin : drive_proc
        logic  taken;
        logic  issue;
        pend_t head;
        if (rst_n)
        begin
            taken = start && !busy;
            issue = 1'b0;
            if (taken)
                expected_q.push_back(scale_grad_predict(cmd));
            if (taken || !start)
            begin
                if (pending_q.size() > 0)
                begin
                    head = pending_q[0];
                    if (!gap_armed)
                    begin
                        idle_left = int'(head.gap);
                        gap_armed = 1'b1;
                    end
                    if (idle_left > 0)
                        idle_left--;
                    else if (!(head.drain && expected_q.size() > 0))
                    begin
                        void'(pending_q.pop_front());
                        cmd       <= head.cmd;
                        issue     = 1'b1;
                        gap_armed = 1'b0;
                    end
                end
                start <= issue;
            end
        end
    end

    // Compare each result strobe with the oldest expectation
    always @(posedge clk)
    begin : watch_proc
        csg_pkg::csg_result_t want;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MSG_CAP)
                    $display("%0t: result with nothing expected: expected none, actual %h",
                             $time, result);
            end
            else
            begin
                want = expected_q.pop_front();
                check_field("y_value", longint'(want.y_value), longint'(result.y_value));
                check_field("x_grad", longint'(want.x_grad), longint'(result.x_grad));
                check_field("gradient_value", longint'(want.gradient_value),
                            longint'(result.gradient_value));
                check_field("saturated", longint'(want.saturated),
                            longint'(result.saturated));
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stim_proc
        int                clears;
        int                pick;
        bit                burst;
        csg_pkg::op_t      op;
        csg_pkg::csg_cmd_t c;
        clears = 0;
        burst  = 1'b0;
        foreach (ch_grad[i]) ch_grad[i] = '0;
        foreach (sp_grad[i]) sp_grad[i] = '0;

        // Directed: reads after reset, extremes, rounding ties
        add_item(make_cmd(csg_pkg::OP_READ_CH, '0, '0, '0, '0, 10'd0, 12'd0), 0, 1'b0);
        add_item(make_cmd(csg_pkg::OP_READ_SP, '0, '0, '0, '0, 10'd0, 12'd4095), 0, 1'b0);
        add_item(make_cmd(csg_pkg::OP_ELEMENT, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                          10'd5, 12'd7), 0, 1'b0);
        add_item(make_cmd(csg_pkg::OP_ELEMENT, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                          10'd6, 12'd8), 0, 1'b0);
        add_item(make_cmd(csg_pkg::OP_ELEMENT, 16'h0100, 16'h0200, 16'h0080, 16'hff00,
                          10'd2, 12'd2), 1, 1'b0);
        add_item(make_cmd(csg_pkg::OP_ELEMENT, 16'h0080, 16'h0100, 16'h0001, 16'h0080,
                          10'd3, 12'd3), 0, 1'b0);
        add_item(make_cmd(csg_pkg::OP_ELEMENT, 16'hff80, 16'h0100, 16'h0001, 16'hff80,
                          10'd3, 12'd3), 0, 1'b0);
        // Push both stores past the positive limit, then past the negative limit
        repeat (5)
            add_item(make_cmd(csg_pkg::OP_ELEMENT, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                              10'd1023, 12'd4095), 0, 1'b0);
        add_item(make_cmd(csg_pkg::OP_READ_CH, '0, '0, '0, '0, 10'd1023, 12'd0), 0, 1'b0);
        add_item(make_cmd(csg_pkg::OP_READ_SP, '0, '0, '0, '0, 10'd0, 12'd4095), 0, 1'b0);
        repeat (5)
            add_item(make_cmd(csg_pkg::OP_ELEMENT, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
                              10'd0, 12'd0), 0, 1'b0);
        add_item(make_cmd(csg_pkg::OP_READ_CH, '0, '0, '0, '0, 10'd0, 12'd0), 0, 1'b0);
        add_item(make_cmd(csg_pkg::OP_READ_SP, '0, '0, '0, '0, 10'd0, 12'd0), 0, 1'b0);
        // Clear with an extreme nonzero payload, then confirm both stores read back zero
        add_item(make_cmd(csg_pkg::OP_CLEAR, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                          10'd1023, 12'd4095), 0, 1'b1);
        add_item(make_cmd(csg_pkg::OP_READ_CH, '0, '0, '0, '0, 10'd1023, 12'd0), 0, 1'b0);
        add_item(make_cmd(csg_pkg::OP_READ_SP, '0, '0, '0, '0, 10'd0, 12'd4095), 0, 1'b0);

        // Random: mostly elements on hot slots, reads of those slots, rare clears
        for (int n = 0; n < ITEM_COUNT; n++)
        begin
            if (n % 150 == 0) burst = ($urandom_range(2) == 0);
            pick = $urandom_range(199);
            if (pick < 140)      op = csg_pkg::OP_ELEMENT;
            else if (pick < 169) op = csg_pkg::OP_READ_CH;
            else if (pick < 198) op = csg_pkg::OP_READ_SP;
            else if (clears < MAX_CLEARS)
            begin
                op = csg_pkg::OP_CLEAR;
                clears++;
            end
            else                 op = csg_pkg::OP_ELEMENT;
            c = make_cmd(op, rand_q88(), rand_q88(), rand_q88(), rand_q88(),
                         rand_ch_slot(), rand_sp_slot());
            add_item(c, burst ? 0 : rand_gap(),
                     (op == csg_pkg::OP_CLEAR) || ($urandom_range(99) == 0));
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every item to go out and every result to come back
        while (pending_q.size() > 0 || start) @(posedge clk);
        while (expected_q.size() > 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
